/* rtl/pmq_pkg.sv */
// shared types and constants of the priority message queue
package pmq_pkg;

    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_RECV = 2'd1,
        OP_ARM  = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_BUSY   = 3'd3,
        ST_BADSIG = 3'd4
    } status_t;

    localparam int PAYLOAD_W  = 64;
    localparam int LEN_IN_W   = 8;
    localparam int LEN_W      = 4;
    localparam int PRIO_IN_W  = 5;
    localparam int SIG_W      = 6;
    localparam int COUNT_W    = 6;

    localparam logic [LEN_W-1:0] MAX_LEN_CAP  = 4'd8;
    localparam logic [SIG_W-1:0] SIG_KILL_NUM = 6'd9;
    localparam logic [SIG_W-1:0] SIG_STOP_NUM = 6'd19;
    localparam logic [SIG_W-1:0] SIG_LAST     = 6'd31;

    // per-cycle command broadcast along the chain
    typedef struct packed {
        logic push;
        logic pop;
    } chain_ctrl_t;

endpackage

/* rtl/pmq_ifs.sv */
// handshake channels of the priority message queue

interface pmq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [63:0] payload;
    logic [7:0]  length;
    logic [4:0]  priority_req;
    logic        notify_by_signal;
    logic [5:0]  signal_number;

    modport source (
        output valid, operation, payload, length, priority_req,
               notify_by_signal, signal_number,
        input  ready
    );
    modport sink (
        input  valid, operation, payload, length, priority_req,
               notify_by_signal, signal_number,
        output ready
    );
endinterface

interface pmq_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] out_payload;
    logic [4:0]  out_priority;
    logic [3:0]  out_length;
    logic        notify_fire;
    logic [5:0]  notify_signal;
    logic [5:0]  message_count;

    modport source (
        output valid, status, out_payload, out_priority, out_length,
               notify_fire, notify_signal, message_count,
        input  ready
    );
    modport sink (
        input  valid, status, out_payload, out_priority, out_length,
               notify_fire, notify_signal, message_count,
        output ready
    );
endinterface

interface pmq_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] max_length;

    modport source (output valid, max_length, input ready);
    modport sink (input valid, max_length, output ready);
endinterface

/* rtl/pmq_cell.sv */
// one slot of the sorted shift chain
module pmq_cell #(
    parameter int PW = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pmq_pkg::chain_ctrl_t  ctrl,
    input  logic [63:0]           new_payload,
    input  logic [PW-1:0]         new_prio,
    input  logic [3:0]            new_len,
    input  logic                  left_keep,
    input  logic                  left_valid,
    input  logic [63:0]           left_payload,
    input  logic [PW-1:0]         left_prio,
    input  logic [3:0]            left_len,
    input  logic                  right_valid,
    input  logic [63:0]           right_payload,
    input  logic [PW-1:0]         right_prio,
    input  logic [3:0]            right_len,
    output logic                  keep,
    output logic                  valid,
    output logic [63:0]           payload,
    output logic [PW-1:0]         prio,
    output logic [3:0]            len
);
    import pmq_pkg::*;

    logic          valid_reg, valid_next;
    logic [63:0]   payload_reg, payload_next;
    logic [PW-1:0] prio_reg, prio_next;
    logic [3:0]    len_reg, len_next;

    // entries of equal or higher priority stay put on insertion
    assign keep = valid_reg && (prio_reg >= new_prio);

    always_comb
    begin
        valid_next   = valid_reg;
        payload_next = payload_reg;
        prio_next    = prio_reg;
        len_next     = len_reg;
        priority if (ctrl.pop)
        begin
            valid_next   = right_valid;
            payload_next = right_payload;
            prio_next    = right_prio;
            len_next     = right_len;
        end
        else if (ctrl.push && !keep)
        begin
            priority if (left_keep)
            begin
                valid_next   = 1'b1;
                payload_next = new_payload;
                prio_next    = new_prio;
                len_next     = new_len;
            end
            else
            begin
                valid_next   = left_valid;
                payload_next = left_payload;
                prio_next    = left_prio;
                len_next     = left_len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        payload_reg <= payload_next;
        prio_reg    <= prio_next;
        len_reg     <= len_next;
    end

    assign valid   = valid_reg;
    assign payload = payload_reg;
    assign prio    = prio_reg;
    assign len     = len_reg;

endmodule

/* rtl/pmq_chain.sv */
// row of cells sorted by descending priority, head at cell 0
module pmq_chain #(
    parameter int DEPTH = 32,
    parameter int PW    = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pmq_pkg::chain_ctrl_t  ctrl,
    input  logic [63:0]           new_payload,
    input  logic [PW-1:0]         new_prio,
    input  logic [3:0]            new_len,
    output logic [63:0]           head_payload,
    output logic [PW-1:0]         head_prio,
    output logic [3:0]            head_len
);
    import pmq_pkg::*;

    logic          keep_w    [DEPTH];
    logic          valid_w   [DEPTH];
    logic [63:0]   payload_w [DEPTH];
    logic [PW-1:0] prio_w    [DEPTH];
    logic [3:0]    len_w     [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic          lk, lv, rv;
            logic [63:0]   lpay, rpay;
            logic [PW-1:0] lpri, rpri;
            logic [3:0]    llen, rlen;

            if (i == 0)
            begin : g_first
                // nothing ranks ahead of the head, so a non-kept head takes the new entry
                assign lk   = 1'b1;
                assign lv   = 1'b0;
                assign lpay = '0;
                assign lpri = '0;
                assign llen = '0;
            end
            else
            begin : g_mid
                assign lk   = keep_w[i-1];
                assign lv   = valid_w[i-1];
                assign lpay = payload_w[i-1];
                assign lpri = prio_w[i-1];
                assign llen = len_w[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign rv   = 1'b0;
                assign rpay = '0;
                assign rpri = '0;
                assign rlen = '0;
            end
            else
            begin : g_inner
                assign rv   = valid_w[i+1];
                assign rpay = payload_w[i+1];
                assign rpri = prio_w[i+1];
                assign rlen = len_w[i+1];
            end

            pmq_cell #(.PW(PW)) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctrl          (ctrl),
                .new_payload   (new_payload),
                .new_prio      (new_prio),
                .new_len       (new_len),
                .left_keep     (lk),
                .left_valid    (lv),
                .left_payload  (lpay),
                .left_prio     (lpri),
                .left_len      (llen),
                .right_valid   (rv),
                .right_payload (rpay),
                .right_prio    (rpri),
                .right_len     (rlen),
                .keep          (keep_w[i]),
                .valid         (valid_w[i]),
                .payload       (payload_w[i]),
                .prio          (prio_w[i]),
                .len           (len_w[i])
            );
        end
    endgenerate

    assign head_payload = payload_w[0];
    assign head_prio    = prio_w[0];
    assign head_len     = len_w[0];

endmodule

/* rtl/priority_message_queue_unit.sv */
// top level of the priority message queue: control, notification and response register
//
//  channel  dir  handshake       carries
//  req      in   valid/ready     operation, payload, length, priority_req, signal fields
//  rsp      out  valid/ready     status, received message, notify result, message_count
//  cfg      in   valid/ready     max_length (ready always high)
//
// one request per cycle unless stalled: the chain inserts or pops in the transfer cycle
// the response appears in the cycle after the transfer, from a single output register
// req.ready is low only while a response waits and rsp.ready is low
// reset empties the chain at once and sets max_length to 8
module priority_message_queue_unit #(
    parameter int QUEUE_DEPTH   = 32,
    parameter int PRIORITY_BITS = 5
) (
    input  logic       clk,
    input  logic       rst_n,
    pmq_req_if.sink    req,
    pmq_rsp_if.source  rsp,
    pmq_cfg_if.sink    cfg
);
    import pmq_pkg::*;

    localparam int PW = (PRIORITY_BITS < PRIO_IN_W) ? PRIORITY_BITS : PRIO_IN_W;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [LEN_W-1:0] max_len_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic             armed_reg, armed_next;
    logic [SIG_W-1:0] armed_sig_reg, armed_sig_next;

    logic                 rsp_valid_reg;
    status_t              status_reg, status_next;
    logic [PAYLOAD_W-1:0] opay_reg, opay_next;
    logic [PRIO_IN_W-1:0] oprio_reg, oprio_next;
    logic [LEN_W-1:0]     olen_reg, olen_next;
    logic                 fire_reg, fire_next;
    logic [SIG_W-1:0]     fsig_reg, fsig_next;
    logic [COUNT_W-1:0]   mcount_reg, mcount_next;

    chain_ctrl_t          ctrl;
    logic                 accept;
    op_t                  op;
    logic                 full, empty, bad_sig;
    logic [PW-1:0]        new_prio;
    logic [LEN_W-1:0]     send_len;
    logic [PAYLOAD_W-1:0] head_payload;
    logic [PW-1:0]        head_prio;
    logic [LEN_W-1:0]     head_len;
    logic [PW+PRIO_IN_W-1:0] head_prio_ext;
    logic [CW+COUNT_W-1:0]   count_ext;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign op        = op_t'(req.operation);
    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign new_prio  = req.priority_req[PW-1:0];
    assign send_len  = (req.length < {4'b0, max_len_reg}) ? req.length[LEN_W-1:0]
                                                          : max_len_reg;
    assign bad_sig   = req.notify_by_signal &&
                       ((req.signal_number == '0) || (req.signal_number > SIG_LAST) ||
                        (req.signal_number == SIG_KILL_NUM) ||
                        (req.signal_number == SIG_STOP_NUM));
    assign head_prio_ext = {{PRIO_IN_W{1'b0}}, head_prio};

    pmq_chain #(.DEPTH(QUEUE_DEPTH), .PW(PW)) u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .new_payload  (req.payload),
        .new_prio     (new_prio),
        .new_len      (send_len),
        .head_payload (head_payload),
        .head_prio    (head_prio),
        .head_len     (head_len)
    );

    always_comb
    begin
        ctrl.push      = 1'b0;
        ctrl.pop       = 1'b0;
        count_next     = count_reg;
        armed_next     = armed_reg;
        armed_sig_next = armed_sig_reg;
        status_next    = ST_OK;
        opay_next      = '0;
        oprio_next     = '0;
        olen_next      = '0;
        fire_next      = 1'b0;
        fsig_next      = '0;
        unique case (op)
            OP_SEND:
            begin
                priority if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl.push  = accept;
                    fire_next  = empty && armed_reg;
                    fsig_next  = (empty && armed_reg) ? armed_sig_reg : '0;
                    count_next = count_reg + CW'(1);
                    armed_next = 1'b0;
                end
            end
            OP_RECV:
            begin
                priority if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    ctrl.pop   = accept;
                    opay_next  = head_payload;
                    oprio_next = head_prio_ext[PRIO_IN_W-1:0];
                    olen_next  = ({4'b0, head_len} < req.length) ? head_len
                                                                 : req.length[LEN_W-1:0];
                    count_next = count_reg - CW'(1);
                end
            end
            OP_ARM:
            begin
                priority if (armed_reg)
                begin
                    status_next = ST_BUSY;
                end
                else if (bad_sig)
                begin
                    status_next = ST_BADSIG;
                end
                else
                begin
                    armed_next     = 1'b1;
                    armed_sig_next = req.notify_by_signal ? req.signal_number : '0;
                end
            end
            OP_NOP:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign count_ext   = {{COUNT_W{1'b0}}, count_next};
    assign mcount_next = count_ext[COUNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            armed_reg     <= 1'b0;
            armed_sig_reg <= '0;
            rsp_valid_reg <= 1'b0;
            max_len_reg   <= MAX_LEN_CAP;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                armed_reg     <= armed_next;
                armed_sig_reg <= armed_sig_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                max_len_reg <= (cfg.max_length > MAX_LEN_CAP) ? MAX_LEN_CAP : cfg.max_length;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            opay_reg   <= opay_next;
            oprio_reg  <= oprio_next;
            olen_reg   <= olen_next;
            fire_reg   <= fire_next;
            fsig_reg   <= fsig_next;
            mcount_reg <= mcount_next;
        end
    end

    assign cfg.ready         = 1'b1;
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.out_payload   = opay_reg;
    assign rsp.out_priority  = oprio_reg;
    assign rsp.out_length    = olen_reg;
    assign rsp.notify_fire   = fire_reg;
    assign rsp.notify_signal = fsig_reg;
    assign rsp.message_count = mcount_reg;

endmodule
